// File: rtl/tlf_pkg.sv
// Shared types, character codes and register helpers for the text line folder.
package tlf_pkg;

	localparam logic [7:0] CH_BLANK   = 8'h20;
	localparam logic [7:0] CH_HYPHEN  = 8'h2D;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_TAB     = 8'h09;

	localparam int LW_W = 6;
	localparam int TW_W = 5;

	localparam logic [LW_W-1:0] LW_RESET = 6'd30;
	localparam logic [TW_W-1:0] TW_RESET = 5'd4;
	localparam logic [LW_W-1:0] LW_MIN   = 6'd2;
	localparam logic [TW_W-1:0] TW_MIN   = 5'd1;
	localparam logic [TW_W-1:0] TW_MAX   = 5'd16;
	localparam int              LW_CAP   = 61;

	// register select, taken from address bit 2
	localparam logic REG_LINE_WIDTH = 1'b0;
	localparam logic REG_TAB_WIDTH  = 1'b1;

	typedef enum logic [1:0] {
		OP_CHAR,
		OP_NL,
		OP_TAB,
		OP_END
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] ch;
	} cmd_t;

	typedef struct packed {
		logic [LW_W-1:0] eff_width;
		logic [TW_W-1:0] eff_tab;
		logic            tab_wr;
	} cfg_t;

	function automatic logic [LW_W-1:0] eff_width(input logic [LW_W-1:0] w,
			input logic [LW_W-1:0] top);
		logic [LW_W-1:0] r;
		if (w < LW_MIN) begin
			r = LW_MIN;
		end else if (w > top) begin
			r = top;
		end else begin
			r = w;
		end
		return r;
	endfunction

	function automatic logic [TW_W-1:0] eff_tab(input logic [TW_W-1:0] t);
		logic [TW_W-1:0] r;
		if (t < TW_MIN) begin
			r = TW_MIN;
		end else if (t > TW_MAX) begin
			r = TW_MAX;
		end else begin
			r = t;
		end
		return r;
	endfunction

endpackage

// File: rtl/tlf_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
module tlf_front import tlf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] in_char,
	input  logic       end_of_input,
	input  logic       item_valid,
	output logic       item_stall,
	output logic       cmd_valid,
	output cmd_t       cmd,
	input  logic       cmd_take
);

	cmd_t       q_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic       push;

	always_comb begin
		cls.ch = in_char;
		if (end_of_input) begin
			cls.op = OP_END;
		end else if (in_char == CH_NEWLINE) begin
			cls.op = OP_NL;
		end else if (in_char == CH_TAB) begin
			cls.op = OP_TAB;
		end else begin
			cls.op = OP_CHAR;
		end
	end

	assign item_stall = (cnt_q == 2'd2);
	assign push       = item_valid && !item_stall;
	assign cmd_valid  = (cnt_q != 2'd0);
	assign cmd        = q_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (cmd_take) begin
				rd_q <= !rd_q;
			end
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, cmd_take});
		end
	end

endmodule

// File: rtl/tlf_back.sv
// Back end: line store, fold/flush sequencer and result queue.
module tlf_back import tlf_pkg::*; #(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       cmd_valid,
	input  cmd_t       cmd,
	output logic       cmd_take,
	output logic [7:0] out_char,
	output logic       last_of_run,
	output logic       result_valid,
	input  logic       result_stall
);

	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int XW = (AW > TW_W) ? AW : TW_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RECALC,
		S_SCAN,
		S_CHK,
		S_EMIT,
		S_HYPH,
		S_NL,
		S_APPEND,
		S_TAB
	} state_t;

	state_t          state_q;
	op_t             op_q;
	logic [7:0]      ch_q;
	logic            fold_q;
	logic            hyph_q;
	logic [AW-1:0]   len_q;
	logic [AW-1:0]   idx_q;
	logic [AW-1:0]   cc_q;
	logic [AW-1:0]   lnb_q;   // one past the last non-blank column
	logic [AW-1:0]   scan_q;
	logic [AW-1:0]   rem_q;
	logic [3:0]      phase_q; // column count modulo tab spacing
	logic            stale_q; // phase needs recomputing after a tab width write

	logic [7:0]      mem [BUFFER_DEPTH];
	logic [7:0]      rd_data_q;

	logic            s1_valid_q;
	logic            s1_mem_q;
	logic [7:0]      s1_char_q;
	logic            s1_last_q;

	logic [7:0]      oq_char_q [2];
	logic            oq_last_q [2];
	logic            oq_wr_q;
	logic            oq_rd_q;
	logic [1:0]      oq_cnt_q;

	logic [AW-1:0]   w;
	logic [TW_W-1:0] t;
	logic [TW_W-1:0] ph_sum;
	logic [3:0]      ph_inc;
	logic [AW-1:0]   cc_inc;
	logic [XW-1:0]   rem_x;
	logic [XW-1:0]   t_x;
	logic            pop;
	logic [1:0]      occ;
	logic            credit;
	logic            issue;
	logic            issue_mem;
	logic [7:0]      issue_char;
	logic            issue_last;
	logic            mem_we;
	logic [AW-1:0]   mem_wa;
	logic [7:0]      mem_wd;
	logic            mem_re;
	logic [AW-1:0]   mem_ra;
	logic [7:0]      s1_data;

	assign w      = cfg.eff_width[AW-1:0];
	assign t      = cfg.eff_tab;
	assign ph_sum = TW_W'({1'b0, phase_q} + 5'd1);
	assign ph_inc = (ph_sum == t) ? 4'd0 : ph_sum[3:0];
	assign cc_inc = AW'(cc_q + AW'(1));
	assign rem_x  = XW'(rem_q);
	assign t_x    = XW'(t);

	assign pop    = result_valid && !result_stall;
	assign occ    = 2'(oq_cnt_q - {1'b0, pop} + {1'b0, s1_valid_q});
	assign credit = (occ < 2'd2);

	assign cmd_take = (state_q == S_IDLE) && cmd_valid && !stale_q;

	always_comb begin
		issue      = 1'b0;
		issue_mem  = 1'b0;
		issue_char = CH_NEWLINE;
		issue_last = 1'b0;
		mem_we     = 1'b0;
		mem_wa     = cc_q;
		mem_wd     = CH_BLANK;
		mem_re     = 1'b0;
		mem_ra     = idx_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_take && cmd.op == OP_CHAR && cc_q < w) begin
					mem_we = 1'b1;
					mem_wd = cmd.ch;
				end
			end
			S_SCAN: begin
				mem_re = 1'b1;
				mem_ra = scan_q;
			end
			S_EMIT: begin
				if (idx_q != len_q && credit) begin
					issue     = 1'b1;
					issue_mem = 1'b1;
					mem_re    = 1'b1;
				end
			end
			S_HYPH: begin
				if (credit) begin
					issue      = 1'b1;
					issue_char = CH_HYPHEN;
				end
			end
			S_NL: begin
				if (credit) begin
					issue      = 1'b1;
					issue_last = !(fold_q && op_q == OP_NL);
				end
			end
			S_APPEND: begin
				mem_we = 1'b1;
				mem_wd = ch_q;
			end
			S_TAB: begin
				mem_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// line store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_ra];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_CHAR;
			ch_q    <= 8'd0;
			fold_q  <= 1'b0;
			hyph_q  <= 1'b0;
			len_q   <= '0;
			idx_q   <= '0;
			cc_q    <= '0;
			lnb_q   <= '0;
			scan_q  <= '0;
			rem_q   <= '0;
			phase_q <= 4'd0;
			stale_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_valid && stale_q) begin
						rem_q   <= cc_q;
						state_q <= S_RECALC;
					end else if (cmd_take) begin
						op_q  <= cmd.op;
						ch_q  <= cmd.ch;
						idx_q <= '0;
						if (cmd.op == OP_END) begin
							len_q   <= cc_q;
							fold_q  <= 1'b0;
							hyph_q  <= 1'b0;
							state_q <= S_EMIT;
						end else if (cc_q >= w) begin
							fold_q <= 1'b1;
							if (lnb_q <= w) begin
								len_q   <= lnb_q;
								hyph_q  <= (lnb_q == w);
								state_q <= S_EMIT;
							end else begin
								scan_q  <= AW'(w - AW'(1));
								state_q <= S_SCAN;
							end
						end else begin
							fold_q <= 1'b0;
							hyph_q <= 1'b0;
							case (cmd.op)
								OP_NL: begin
									len_q   <= cc_q;
									state_q <= S_EMIT;
								end
								OP_TAB: begin
									state_q <= S_TAB;
								end
								default: begin
									cc_q    <= cc_inc;
									phase_q <= ph_inc;
									if (cmd.ch != CH_BLANK) begin
										lnb_q <= cc_inc;
									end
								end
							endcase
						end
					end
				end
				S_RECALC: begin
					if (rem_x >= t_x) begin
						rem_q <= AW'(rem_x - t_x);
					end else begin
						phase_q <= 4'(rem_x);
						stale_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (rd_data_q != CH_BLANK) begin
						len_q   <= AW'(scan_q + AW'(1));
						hyph_q  <= (scan_q == AW'(w - AW'(1)));
						state_q <= S_EMIT;
					end else if (scan_q == '0) begin
						len_q   <= '0;
						hyph_q  <= 1'b0;
						state_q <= S_EMIT;
					end else begin
						scan_q  <= AW'(scan_q - AW'(1));
						state_q <= S_SCAN;
					end
				end
				S_EMIT: begin
					if (idx_q == len_q) begin
						state_q <= hyph_q ? S_HYPH : S_NL;
					end else if (credit) begin
						idx_q <= AW'(idx_q + AW'(1));
					end
				end
				S_HYPH: begin
					if (credit) begin
						state_q <= S_NL;
					end
				end
				S_NL: begin
					if (credit) begin
						cc_q    <= '0;
						lnb_q   <= '0;
						phase_q <= 4'd0;
						stale_q <= 1'b0;
						if (fold_q) begin
							fold_q <= 1'b0;
							case (op_q)
								OP_NL:   state_q <= S_NL;
								OP_TAB:  state_q <= S_TAB;
								OP_CHAR: state_q <= S_APPEND;
								default: state_q <= S_IDLE;
							endcase
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_APPEND: begin
					cc_q    <= cc_inc;
					phase_q <= ph_inc;
					if (ch_q != CH_BLANK) begin
						lnb_q <= cc_inc;
					end
					state_q <= S_IDLE;
				end
				S_TAB: begin
					cc_q    <= cc_inc;
					phase_q <= ph_inc;
					if (ph_inc == 4'd0 || cc_inc == w) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cfg.tab_wr) begin
				stale_q <= 1'b1;
			end
		end
	end

	// read stage: store data is registered and arrives in the cycle after the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= issue;
		end
	end

	always_ff @(posedge clk) begin
		s1_mem_q  <= issue_mem;
		s1_char_q <= issue_char;
		s1_last_q <= issue_last;
	end

	assign s1_data = s1_mem_q ? rd_data_q : s1_char_q;

	// result queue, two entries
	always_ff @(posedge clk) begin
		if (s1_valid_q) begin
			oq_char_q[oq_wr_q] <= s1_data;
			oq_last_q[oq_wr_q] <= s1_last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= 1'b0;
			oq_rd_q  <= 1'b0;
			oq_cnt_q <= 2'd0;
		end else begin
			if (s1_valid_q) begin
				oq_wr_q <= !oq_wr_q;
			end
			if (pop) begin
				oq_rd_q <= !oq_rd_q;
			end
			oq_cnt_q <= 2'(oq_cnt_q + {1'b0, s1_valid_q} - {1'b0, pop});
		end
	end

	assign result_valid = (oq_cnt_q != 2'd0);
	assign out_char     = oq_char_q[oq_rd_q];
	assign last_of_run  = oq_last_q[oq_rd_q];

endmodule

// File: rtl/text_line_folder.sv
// Text line folder: top level with APB register block, front end and back end.
//
// Folds a stream of character requests into lines of at most line_width columns.
// Each request carries one byte, or an end-of-input mark. Ordinary bytes are
// appended to a line store; a tab is expanded to blanks up to the next tab stop
// and never runs past the fold column. A newline, or the end of input, writes
// the buffered line out followed by a newline. When the store already holds a
// full line, the next byte first folds it: trailing blanks are dropped, a
// hyphen is added when the last column is non-blank, then a newline follows.
// Results leave one character per result request; last_of_run marks the final
// character that one input request caused, and a request that causes nothing
// yields no result. In the back end a tab writes one blank at a time, at most
// tab_width blanks in all; a newline, end of input or fold reads the line out
// character by character, as the line store has a single read port with
// registered data. After line_width is lowered below the last non-blank
// column, a fold searches the store backwards column by column through
// S_SCAN and S_CHK. After a tab_width write, the next request waits while
// the tab phase is recomputed. A two-entry request queue sits between front
// and back, and a two-entry result queue decouples the output, so either
// side may stall freely.
// Registers: line_width at byte address 0 (reset 30, clamped to 2..61 and to
// BUFFER_DEPTH-3), tab_width at address 4 (reset 4, clamped to 1..16). Write
// them only while the block is idle. No clearing pass is needed after reset.
module text_line_folder import tlf_pkg::*; #(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// request channel
	input  logic [7:0]  in_char,
	input  logic        end_of_input,
	input  logic        item_valid,
	output logic        item_stall,
	// result channel
	output logic [7:0]  out_char,
	output logic        last_of_run,
	output logic        result_valid,
	input  logic        result_stall
);

	// widest fold column: the smaller of LW_CAP and BUFFER_DEPTH-3
	localparam int              TOP_I = (BUFFER_DEPTH - 3 > LW_CAP) ? LW_CAP : BUFFER_DEPTH - 3;
	localparam logic [LW_W-1:0] W_TOP = LW_W'(TOP_I);

	logic [LW_W-1:0] lw_q;
	logic [TW_W-1:0] tw_q;
	logic            reg_wr;
	cfg_t            cfg;
	logic            cmd_valid;
	cmd_t            cmd;
	logic            cmd_take;

	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready;

	// register writes; address bit 2 selects the register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_q <= LW_RESET;
			tw_q <= TW_RESET;
		end else if (reg_wr) begin
			case (paddr[2])
				REG_LINE_WIDTH: lw_q <= pwdata[LW_W-1:0];
				REG_TAB_WIDTH:  tw_q <= pwdata[TW_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_LINE_WIDTH: prdata = {{(32-LW_W){1'b0}}, lw_q};
			REG_TAB_WIDTH:  prdata = {{(32-TW_W){1'b0}}, tw_q};
			default:        prdata = 32'd0;
		endcase
	end

	// clamped values; a tab width write also flags the tab phase as stale
	assign cfg.eff_width = eff_width(lw_q, W_TOP);
	assign cfg.eff_tab   = eff_tab(tw_q);
	assign cfg.tab_wr    = reg_wr && (paddr[2] == REG_TAB_WIDTH);

	tlf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_char      (in_char),
		.end_of_input (end_of_input),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_take     (cmd_take)
	);

	tlf_back #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_take     (cmd_take),
		.out_char     (out_char),
		.last_of_run  (last_of_run),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

endmodule

// File: rtl/tlf_checker.sv
// Port-level checks for the text line folder, bound to the top level.
module tlf_checker import tlf_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready,
	input logic [7:0]  in_char,
	input logic        end_of_input,
	input logic        item_valid,
	input logic        item_stall,
	input logic [7:0]  out_char,
	input logic        last_of_run,
	input logic        result_valid,
	input logic        result_stall
);

	logic reg_wr;

	assign reg_wr = psel && penable && pwrite && pready;

	// a stalled request holds
	a_request_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=>
		item_valid && $stable(in_char) && $stable(end_of_input))
		else $error("stalled request changed");

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
		result_valid && $stable(out_char) && $stable(last_of_run))
		else $error("stalled result changed");

	// every run of results closes with a newline
	a_last_is_newline: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_of_run |-> out_char == CH_NEWLINE)
		else $error("run ended on a character other than newline");

	// register readback after a write
	a_width_readback: assert property (@(posedge clk) disable iff (!arst_n)
		reg_wr && paddr[2] == REG_LINE_WIDTH |=>
		paddr[2] != REG_LINE_WIDTH || prdata[LW_W-1:0] == $past(pwdata[LW_W-1:0]))
		else $error("line_width readback mismatch");

	a_tab_readback: assert property (@(posedge clk) disable iff (!arst_n)
		reg_wr && paddr[2] == REG_TAB_WIDTH |=>
		paddr[2] != REG_TAB_WIDTH || prdata[TW_W-1:0] == $past(pwdata[TW_W-1:0]))
		else $error("tab_width readback mismatch");

endmodule

bind text_line_folder tlf_checker u_tlf_checker (.*);

// File: sim/text_line_folder_tb.sv
// Self-checking testbench for the text line folder: directed table, random text, APB setup.
module text_line_folder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tlf_pkg::*;

	localparam int BUF_DEPTH     = 64;
	localparam int MAX_RUN       = 64;      // most characters one request can cause
	localparam int SETTLE_CYCLES = 200;     // covers the backward search and tab phase recompute
	localparam int HOLD_CYCLES   = 400;     // long receiver hold-off, fills both queues
	localparam int CYCLE_LIMIT   = 2000000;
	localparam int REPORT_MAX    = 10;
	localparam int PHASE_COUNT   = 8;
	localparam int PHASE_ITEMS   = 30;
	localparam int PREDICT       = -1;      // table row leaves the expectation to the predictor

	localparam logic [2:0] ADDR_LINE_WIDTH = {REG_LINE_WIDTH, 2'b00};
	localparam logic [2:0] ADDR_TAB_WIDTH  = {REG_TAB_WIDTH, 2'b00};

	// one emitted character as seen on the result channel
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} glyph_t;

	// one row of the directed table: either a register write or a request
	typedef struct packed {
		logic              is_cfg;
		logic [2:0]        addr;
		logic [31:0]       data;
		logic [7:0]        ch;
		logic              eoi;
		logic signed [7:0] exp_n;
		logic [63:0]       exp_txt;
	} script_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic [7:0]  in_char;
	logic        end_of_input;
	logic        item_valid;
	logic        item_stall;
	logic [7:0]  out_char;
	logic        last_of_run;
	logic        result_valid;
	logic        result_stall;

	// predictor state: its own copy of the line store, column count and registers
	logic [7:0] line_buf [0:BUF_DEPTH-1];
	int         col_cnt;
	logic [5:0] width_reg;
	logic [4:0] tab_reg;

	glyph_t      step_chars[$];    // characters the latest request causes
	glyph_t      folded_q[$];      // characters still awaited on the result channel
	script_row_t script_q[$];

	int   bad_cnt;
	int   chars_seen;
	int   cycle_cnt;
	bit   sender_calm;
	logic hold_armed;

	text_line_folder #(
		.BUFFER_DEPTH(BUF_DEPTH)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_char     (in_char),
		.end_of_input(end_of_input),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.out_char    (out_char),
		.last_of_run (last_of_run),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// fold column as the block sees it: clamped to 2..depth-3
	function automatic int fold_width();
		int w;
		w = width_reg;
		if (w < 2) w = 2;
		if (w > BUF_DEPTH - 3) w = BUF_DEPTH - 3;
		return w;
	endfunction

	function automatic void emit_char(input logic [7:0] ch);
		glyph_t g;
		g.ch = ch;
		g.last = 1'b0;
		if (step_chars.size() < MAX_RUN) step_chars.push_back(g);
	endfunction

	// works out the characters one request causes and advances the line state
	function automatic void fold_step(input logic [7:0] ch, input logic eoi);
		int     w;
		int     t;
		int     last;
		int     blanks;
		glyph_t g;
		w = fold_width();
		t = tab_reg;
		if (t < 1) t = 1;
		if (t > 16) t = 16;
		step_chars.delete();
		// full line (or width lowered under it): fold before the byte is handled
		if (!eoi && col_cnt >= w) begin
			last = -1;
			for (int i = w - 1; i >= 0 && last < 0; i--) begin
				if (line_buf[i] != CH_BLANK) last = i;
			end
			for (int i = 0; i <= last; i++) emit_char(line_buf[i]);
			if (last == w - 1) emit_char(CH_HYPHEN);
			emit_char(CH_NEWLINE);
			col_cnt = 0;
		end
		if (eoi || ch == CH_NEWLINE) begin
			// line goes out untrimmed
			for (int i = 0; i < col_cnt; i++) emit_char(line_buf[i]);
			emit_char(CH_NEWLINE);
			col_cnt = 0;
		end else if (ch == CH_TAB) begin
			blanks = t - (col_cnt % t);
			if (blanks > w - col_cnt) blanks = w - col_cnt;
			repeat (blanks) begin
				line_buf[col_cnt] = CH_BLANK;
				col_cnt++;
			end
		end else begin
			line_buf[col_cnt] = ch;
			col_cnt++;
		end
		if (step_chars.size() > 0) begin
			g = step_chars.pop_back();
			g.last = 1'b1;
			step_chars.push_back(g);
		end
	endfunction

	function automatic script_row_t cfg_row(input logic [2:0] addr, input logic [31:0] data);
		script_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.addr = addr;
		r.data = data;
		return r;
	endfunction

	function automatic script_row_t char_row(input logic [7:0] ch, input logic eoi,
			input int n, input logic [63:0] txt);
		script_row_t r;
		r = '0;
		r.ch = ch;
		r.eoi = eoi;
		r.exp_n = 8'(n);
		r.exp_txt = txt;
		return r;
	endfunction

	// sender gap: mostly none or short, now and then long; none at all in calm phases
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (sender_calm || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic report_fault(input string what, input glyph_t want, input glyph_t got);
		bad_cnt++;
		if (bad_cnt <= REPORT_MAX)
			$display("char %0d: %s, expected %h/%b, got %h/%b", chars_seen, what,
				want.ch, want.last, got.ch, got.last);
	endtask

	// returns at the edge where the request is taken
	task automatic offer_char(input logic [7:0] ch, input logic eoi);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid   <= 1'b1;
		in_char      <= ch;
		end_of_input <= eoi;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic push_text(input logic [7:0] ch, input logic eoi);
		offer_char(ch, eoi);
		fold_step(ch, eoi);
		foreach (step_chars[i]) folded_q.push_back(step_chars[i]);
	endtask

	// register writes only once every character is out and the back end has gone quiet
	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		item_valid <= 1'b0;
		while (folded_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr[2] == REG_TAB_WIDTH) tab_reg = data[4:0];
		else width_reg = data[5:0];
	endtask

	// result checker: compares at the accepting edge, pre-edge values
	always @(posedge clk) begin
		glyph_t got;
		glyph_t want;
		if (arst_n === 1'b1 && result_valid && !result_stall) begin
			got.ch = out_char;
			got.last = last_of_run;
			if (folded_q.size() == 0) begin
				report_fault("no character awaited", '0, got);
			end else begin
				want = folded_q.pop_front();
				if (want.ch !== got.ch || want.last !== got.last)
					report_fault("mismatch", want, got);
			end
			chars_seen++;
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// receiver: runs of stall and no stall, calm stretches, one long hold when armed
	initial begin : result_drain
		int   len;
		int   r;
		logic stall_val;
		bit   held;
		held = 1'b0;
		result_stall <= 1'b0;
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (hold_armed && !held) begin
				held = 1'b1;
				stall_val = 1'b1;
				len = HOLD_CYCLES;
			end else if (r < 10) begin
				stall_val = 1'b0;
				len = $urandom_range(50, 150);
			end else if (r < 55) begin
				stall_val = 1'b0;
				len = $urandom_range(1, 6);
			end else if (r < 92) begin
				stall_val = 1'b1;
				len = $urandom_range(1, 3);
			end else begin
				stall_val = 1'b1;
				len = $urandom_range(10, 40);
			end
			result_stall <= stall_val;
			// an armed hold cuts the current run short
			for (int k = 0; k < len; k++) begin
				if (hold_armed && !held) break;
				@(posedge clk);
			end
		end
	end

	initial begin : stimulus
		script_row_t row;
		glyph_t      g;
		logic [7:0]  c;
		logic        e;
		logic [31:0] wdata;
		int          lw_set [0:PHASE_COUNT-2];
		int          tw_set [0:PHASE_COUNT-2];
		int          sent;
		int          stop;
		int          r;
		bit          long_lines;

		// settings per random phase; the last phase draws its own
		lw_set = '{30, 2, 61, 63, 0, 1, 10};
		tw_set = '{4, 1, 16, 0, 31, 17, 3};

		bad_cnt = 0;
		chars_seen = 0;
		cycle_cnt = 0;
		sender_calm = 1'b0;
		col_cnt = 0;
		width_reg = LW_RESET;
		tab_reg = TW_RESET;

		arst_n       <= 1'b0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		in_char      <= '0;
		end_of_input <= 1'b0;
		item_valid   <= 1'b0;
		hold_armed   <= 1'b0;

		// directed table
		// bare newline and bare end straight after reset
		script_q.push_back(char_row(CH_NEWLINE, 1'b0, 1, "\n"));
		script_q.push_back(char_row(8'h00, 1'b1, 1, "\n"));
		// narrowest line: fold with hyphen, trimmed fold, tab cut at the fold column
		script_q.push_back(cfg_row(ADDR_LINE_WIDTH, 32'd2));
		script_q.push_back(char_row("a", 1'b0, 0, ""));
		script_q.push_back(char_row("b", 1'b0, 0, ""));
		script_q.push_back(char_row("c", 1'b0, 4, "ab-\n"));
		script_q.push_back(char_row(" ", 1'b0, 0, ""));
		script_q.push_back(char_row("d", 1'b0, 2, "c\n"));
		script_q.push_back(char_row(CH_TAB, 1'b0, 0, ""));
		script_q.push_back(char_row("e", 1'b0, 2, "d\n"));
		// end with a newline byte: the byte itself is ignored
		script_q.push_back(char_row(CH_NEWLINE, 1'b1, 2, "e\n"));
		// widest settings, byte extremes
		script_q.push_back(cfg_row(ADDR_LINE_WIDTH, 32'd61));
		script_q.push_back(cfg_row(ADDR_TAB_WIDTH, 32'd16));
		script_q.push_back(char_row(CH_TAB, 1'b0, 0, ""));
		script_q.push_back(char_row(8'hFF, 1'b0, 0, ""));
		script_q.push_back(char_row(8'h00, 1'b0, 0, ""));
		script_q.push_back(char_row(CH_NEWLINE, 1'b0, PREDICT, ""));
		// tab width zero taken as one; an all-blank fold gives a newline alone
		script_q.push_back(cfg_row(ADDR_TAB_WIDTH, 32'd0));
		script_q.push_back(cfg_row(ADDR_LINE_WIDTH, 32'd3));
		script_q.push_back(char_row(CH_TAB, 1'b0, 0, ""));
		script_q.push_back(char_row(CH_TAB, 1'b0, 0, ""));
		script_q.push_back(char_row(CH_TAB, 1'b0, 0, ""));
		script_q.push_back(char_row("x", 1'b0, 1, "\n"));
		script_q.push_back(char_row("y", 1'b0, 0, ""));
		script_q.push_back(char_row("z", 1'b0, 0, ""));
		// width lowered under a buffered line (1 clamps to 2): the tail is dropped
		script_q.push_back(cfg_row(ADDR_LINE_WIDTH, 32'd1));
		script_q.push_back(char_row("q", 1'b0, 4, "xy-\n"));
		script_q.push_back(char_row(8'hFF, 1'b1, 2, "q\n"));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script_q[k]) begin
			row = script_q[k];
			if (row.is_cfg) begin
				write_reg(row.addr, row.data);
			end else if (row.exp_n == PREDICT) begin
				push_text(row.ch, row.eoi);
			end else begin
				// typed rows still step the predictor to keep its line state
				offer_char(row.ch, row.eoi);
				fold_step(row.ch, row.eoi);
				for (int i = 0; i < row.exp_n; i++) begin
					g.ch = row.exp_txt[8*(row.exp_n-1-i) +: 8];
					g.last = (i == row.exp_n - 1);
					folded_q.push_back(g);
				end
			end
		end

		// random text in phases, each under its own register settings
		sent = 0;
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			wdata = $urandom;
			wdata[5:0] = (phase < PHASE_COUNT - 1) ? 6'(lw_set[phase]) : 6'($urandom_range(0, 63));
			write_reg(ADDR_LINE_WIDTH, wdata);
			wdata = $urandom;
			wdata[4:0] = (phase < PHASE_COUNT - 1) ? 5'(tw_set[phase]) : 5'($urandom_range(0, 31));
			write_reg(ADDR_TAB_WIDTH, wdata);
			sender_calm = (phase % 3 == 2);
			long_lines = (phase == 2 || phase == 3 || phase == 6);
			stop = (phase + 1) * PHASE_ITEMS;
			// wide lines, sender keeps offering while the receiver holds off
			if (phase == 2) begin
				hold_armed <= 1'b1;
				// newlines back up behind the held results until the input stalls
				repeat (8) begin
					push_text(CH_NEWLINE, 1'b0);
					sent++;
				end
			end
			while (sent < stop) begin
				r = $urandom_range(0, 99);
				if (long_lines && r < 4) begin
					// run the line up to the fold column, then a newline or one more byte
					while (col_cnt < fold_width()) begin
						c = ($urandom_range(0, 4) == 0) ? CH_BLANK :
							8'($urandom_range(8'h21, 8'h7E));
						push_text(c, 1'b0);
						sent++;
					end
					c = $urandom_range(0, 1) ? CH_NEWLINE : 8'($urandom_range(8'h21, 8'h7E));
					push_text(c, 1'b0);
					sent++;
				end else begin
					e = 1'b0;
					if (r < (long_lines ? 1 : 3)) begin
						e = 1'b1;
						c = 8'($urandom_range(0, 255));
					end else if (r < 12) begin
						c = 8'($urandom_range(0, 255));
					end else if (r < 16) begin
						c = CH_TAB;
					end else if (r < (long_lines ? 17 : 22)) begin
						c = CH_NEWLINE;
					end else if (r < 34) begin
						c = CH_BLANK;
					end else begin
						c = 8'($urandom_range(8'h21, 8'h7E));
					end
					push_text(c, e);
					sent++;
				end
			end
		end

		item_valid <= 1'b0;
		while (folded_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (bad_cnt == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
